// File: rtl/gic_pkg.sv
// Package for the gamepad input conditioner: widths, reset constants, shared types.
// Depends on nothing; used by every module of the block but gic_divider.
`timescale 1ns / 1ps
package gic_pkg;
   localparam int ADC_BITS_DEFAULT          = 10;
   localparam int BUTTON_COUNT_DEFAULT      = 10;
   localparam int INITIAL_HALF_SPAN_DEFAULT = 100;
   localparam int BTN_W     = 10;   // button field width
   localparam int ADC_W     = 10;   // raw reading field width
   localparam int QRY_W     = 4;
   localparam int NORM_W    = 11;
   localparam int DZ_W      = 10;
   localparam int DZ_RESET  = 205;
   localparam int NUM_AXES  = 4;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADZONE = 1'b0;
   localparam int QUEUE_DEPTH = 2;

   // Button results worked out by the front end.
   typedef struct packed {
      logic [BTN_W-1:0] held;
      logic [BTN_W-1:0] pressed;
      logic [BTN_W-1:0] released;
      logic             changed;
      logic             q_pressed;
      logic             q_released;
      logic             q_held;
   } btn_res_type;
endpackage

// File: rtl/gic_front.sv
// Front end: accepts a poll word, does button edge detection and axis calibration.
// Depends on gic_pkg. Hands (offset, span) per axis to the back end through a queue.
`timescale 1ns / 1ps
module gic_front #(
   parameter int ADC_BITS          = gic_pkg::ADC_BITS_DEFAULT,
   parameter int BUTTON_COUNT      = gic_pkg::BUTTON_COUNT_DEFAULT,
   parameter int INITIAL_HALF_SPAN = gic_pkg::INITIAL_HALF_SPAN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [gic_pkg::BTN_W-1:0]     levels,
   input  logic [gic_pkg::ADC_W-1:0]     raw [gic_pkg::NUM_AXES],
   input  logic [gic_pkg::QRY_W-1:0]     query,
   output gic_pkg::btn_res_type          btn,
   output logic [ADC_BITS-1:0]           offset [gic_pkg::NUM_AXES],
   output logic [ADC_BITS-1:0]           span   [gic_pkg::NUM_AXES]
);
   localparam logic [ADC_BITS-1:0] MIN_RST =
      ADC_BITS'((1 << (ADC_BITS-1)) - INITIAL_HALF_SPAN);
   localparam logic [ADC_BITS-1:0] MAX_RST =
      ADC_BITS'((1 << (ADC_BITS-1)) + INITIAL_HALF_SPAN);
   localparam logic [gic_pkg::BTN_W-1:0] BMASK =
      gic_pkg::BTN_W'((64'd1 << BUTTON_COUNT) - 64'd1);

   logic [gic_pkg::BTN_W-1:0] prev_ff, prev_in;
   logic [ADC_BITS-1:0] min_ff [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] max_ff [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] min_in [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] max_in [gic_pkg::NUM_AXES];
   logic [gic_pkg::BTN_W-1:0] cur;
   logic [ADC_BITS-1:0] v;

   always_comb begin
      cur = levels & BMASK;
      prev_in = cur;
      btn.held     = ~cur & BMASK;
      btn.pressed  = prev_ff & ~cur & BMASK;
      btn.released = cur & ~prev_ff & BMASK;
      btn.changed  = (cur != prev_ff);
      btn.q_pressed = 1'b0;
      btn.q_released = 1'b0;
      btn.q_held = 1'b0;
      if (32'(query) < BUTTON_COUNT) begin
         btn.q_pressed  = btn.pressed[query];
         btn.q_released = btn.released[query];
         btn.q_held     = btn.held[query];
      end
      for (int a = 0; a < gic_pkg::NUM_AXES; a++) begin
         v = ADC_BITS'(raw[a]);
         min_in[a] = (v < min_ff[a]) ? v : min_ff[a];
         max_in[a] = (v > max_ff[a]) ? v : max_ff[a];
         offset[a] = v - min_in[a];
         span[a]   = max_in[a] - min_in[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= BMASK;
         for (int a = 0; a < gic_pkg::NUM_AXES; a++) begin
            min_ff[a] <= MIN_RST;
            max_ff[a] <= MAX_RST;
         end
      end else if (take) begin
         prev_ff <= prev_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end
endmodule

// File: rtl/gic_queue.sv
// Small two-entry queue between front and back end.
// Depends on gic_pkg for its depth constant.
`timescale 1ns / 1ps
module gic_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [gic_pkg::QUEUE_DEPTH];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign full  = (cnt_ff == 2'(gic_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == 2'd0);
   assign dout  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= din;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule

// File: rtl/gic_divider.sv
// Radix-2 restoring divider: quotient = (offset << ADC_BITS) / span, one bit a cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module gic_divider #(
   parameter int ADC_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ADC_BITS-1:0] offset,
   input  logic [ADC_BITS-1:0] span,
   output logic                done,
   output logic [ADC_BITS:0]   quotient
);
   localparam int NW = 2*ADC_BITS;          // numerator width
   localparam int CW = $clog2(NW+1);
   logic [NW-1:0]     num_ff;
   logic [ADC_BITS:0] rem_ff;                // one guard bit
   logic [ADC_BITS-1:0] den_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff, done_ff, zero_ff;
   logic [ADC_BITS:0] trial;
   logic [ADC_BITS+1:0] diff;

   always_comb begin
      trial = {rem_ff[ADC_BITS-1:0], num_ff[NW-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
   end

   // quotient never exceeds 2^ADC_BITS since offset <= span
   assign quotient = zero_ff ? '0 : num_ff[ADC_BITS:0];
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         num_ff <= {offset, ADC_BITS'(0)};
         rem_ff <= '0;
         den_ff <= span;
         zero_ff <= (span == '0);
      end else if (busy_ff) begin
         if (!diff[ADC_BITS+1]) begin
            rem_ff <= diff[ADC_BITS:0];
            num_ff <= {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            num_ff <= {num_ff[NW-2:0], 1'b0};
         end
      end
   end
endmodule

// File: rtl/gic_back.sv
// Back end: scales four axes through one shared divider, then the deadzone test.
// Depends on gic_pkg and gic_divider.
`timescale 1ns / 1ps
module gic_back #(
   parameter int ADC_BITS = gic_pkg::ADC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_take,
   input  gic_pkg::btn_res_type          btn,
   input  logic [ADC_BITS-1:0]           offset [gic_pkg::NUM_AXES],
   input  logic [ADC_BITS-1:0]           span   [gic_pkg::NUM_AXES],
   input  logic [gic_pkg::DZ_W-1:0]      deadzone,
   output logic                          out_valid,
   input  logic                          out_take,
   output gic_pkg::btn_res_type          out_btn,
   output logic signed [gic_pkg::NORM_W-1:0] out_norm [gic_pkg::NUM_AXES],
   output logic                          out_active
);
   localparam int HALF = 1 << (ADC_BITS-1);
   typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_SQX, S_SQY, S_DONE} st_type;

   st_type st_ff;
   logic [1:0] ax_ff;
   logic start_ff;
   logic signed [gic_pkg::NORM_W-1:0] norm_ff [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] off_ff  [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] span_ff [gic_pkg::NUM_AXES];
   logic [21:0] mag_ff;
   logic active_ff;
   gic_pkg::btn_res_type btn_ff;
   logic div_done;
   logic [ADC_BITS:0] quo;
   logic signed [ADC_BITS+1:0] centered;
   logic signed [gic_pkg::NORM_W-1:0] nv, sq_src;
   logic signed [21:0] sq_wide;
   logic [19:0] rad_sq;

   // divider reads the word held here, the queue moves on once it is taken
   gic_divider #(.ADC_BITS(ADC_BITS)) u_div (
      .clock, .reset, .start(start_ff), .offset(off_ff[ax_ff]), .span(span_ff[ax_ff]),
      .done(div_done), .quotient(quo));

   always_comb begin
      centered = $signed({1'b0, quo}) - (ADC_BITS+2)'(HALF);
      // offset scaled to 1024 full scale regardless of ADC width
      nv = gic_pkg::NORM_W'(centered <<< (10 - (ADC_BITS > 10 ? 10 : ADC_BITS))
                            >>> (ADC_BITS > 10 ? ADC_BITS - 10 : 0));
      if (ax_ff == 2'd1 || ax_ff == 2'd2) nv = -nv;
      sq_src = (st_ff == S_SQX) ? norm_ff[0] : norm_ff[1];
      sq_wide = 22'(sq_src);
      rad_sq = 20'(deadzone) * 20'(deadzone);
   end

   assign in_take    = (st_ff == S_IDLE) && in_valid;
   assign out_valid  = (st_ff == S_DONE);
   assign out_btn    = btn_ff;
   assign out_norm   = norm_ff;
   assign out_active = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         start_ff <= 1'b0;
         ax_ff <= 2'd0;
      end else begin
         start_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (in_valid) begin
               btn_ff <= btn;
               off_ff <= offset;
               span_ff <= span;
               ax_ff <= 2'd0;
               start_ff <= 1'b1;
               st_ff <= S_WAIT;
            end
            S_START: begin
               start_ff <= 1'b1;
               st_ff <= S_WAIT;
            end
            S_WAIT: if (div_done) begin
               norm_ff[ax_ff] <= nv;
               if (ax_ff == 2'd3) st_ff <= S_SQX;
               else begin
                  ax_ff <= ax_ff + 2'd1;
                  st_ff <= S_START;
               end
            end
            S_SQX: begin
               mag_ff <= sq_wide * sq_wide;
               st_ff <= S_SQY;
            end
            S_SQY: begin
               st_ff <= S_DONE;
               active_ff <= (mag_ff + sq_wide * sq_wide) > {2'b00, rad_sq};
            end
            S_DONE: if (out_take) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/gamepad_input_conditioner_core.sv
// Top level of the gamepad input conditioner: queue ports, CSR port, front and back ends.
// Depends on gic_pkg, gic_front, gic_queue, gic_back (which holds gic_divider).
`timescale 1ns / 1ps
// One poll word carries ten active-low buttons, four stick readings and a query
// number, and yields one result word. The front end does edge detection and widens
// each axis range in the cycle the word is pushed; a two-entry queue decouples it
// from the back end, which scales each axis through one shared radix-2 divider,
// restarted for each axis, and then squares stick 1 for the deadzone test. Results
// wait in the back end's output register until popped; the back end takes no new
// poll until then.
// deadzone_radius sits at byte address 0 of the CSR port.
module gamepad_input_conditioner_core #(
   parameter int ADC_BITS          = gic_pkg::ADC_BITS_DEFAULT,
   parameter int BUTTON_COUNT      = gic_pkg::BUTTON_COUNT_DEFAULT,
   parameter int INITIAL_HALF_SPAN = gic_pkg::INITIAL_HALF_SPAN_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [gic_pkg::BTN_W-1:0] req_button_levels,
   input  logic [gic_pkg::ADC_W-1:0] req_stick1_x_raw,
   input  logic [gic_pkg::ADC_W-1:0] req_stick1_y_raw,
   input  logic [gic_pkg::ADC_W-1:0] req_stick2_x_raw,
   input  logic [gic_pkg::ADC_W-1:0] req_stick2_y_raw,
   input  logic [gic_pkg::QRY_W-1:0] req_query_button,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [gic_pkg::BTN_W-1:0] rsp_held_mask,
   output logic [gic_pkg::BTN_W-1:0] rsp_pressed_mask,
   output logic [gic_pkg::BTN_W-1:0] rsp_released_mask,
   output logic rsp_any_changed,
   output logic rsp_query_pressed,
   output logic rsp_query_released,
   output logic rsp_query_held,
   output logic signed [gic_pkg::NORM_W-1:0] rsp_stick1_x_norm,
   output logic signed [gic_pkg::NORM_W-1:0] rsp_stick1_y_norm,
   output logic signed [gic_pkg::NORM_W-1:0] rsp_stick2_x_norm,
   output logic signed [gic_pkg::NORM_W-1:0] rsp_stick2_y_norm,
   output logic rsp_stick1_active,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [gic_pkg::CSR_ADDR_W+1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int QW = $bits(gic_pkg::btn_res_type) + 8*ADC_BITS;

   logic [gic_pkg::DZ_W-1:0] dz_ff;
   logic [gic_pkg::ADC_W-1:0] raw [gic_pkg::NUM_AXES];
   gic_pkg::btn_res_type f_btn, b_btn, o_btn;
   logic [ADC_BITS-1:0] f_off [gic_pkg::NUM_AXES], f_span [gic_pkg::NUM_AXES];
   logic [ADC_BITS-1:0] b_off [gic_pkg::NUM_AXES], b_span [gic_pkg::NUM_AXES];
   logic [QW-1:0] q_din, q_dout;
   logic take, q_empty, b_take, o_valid;
   logic signed [gic_pkg::NORM_W-1:0] o_norm [gic_pkg::NUM_AXES];

   // CSR: single register, pready tied high
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[gic_pkg::CSR_ADDR_W+1:2] == gic_pkg::CSR_DEADZONE)
                       ? 32'(dz_ff) : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) dz_ff <= gic_pkg::DZ_W'(gic_pkg::DZ_RESET);
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[gic_pkg::CSR_ADDR_W+1:2] == gic_pkg::CSR_DEADZONE)
         dz_ff <= csr_pwdata[gic_pkg::DZ_W-1:0];
   end

   assign raw[0] = req_stick1_x_raw;
   assign raw[1] = req_stick1_y_raw;
   assign raw[2] = req_stick2_x_raw;
   assign raw[3] = req_stick2_y_raw;
   assign take = req_push && !req_full;

   gic_front #(.ADC_BITS(ADC_BITS), .BUTTON_COUNT(BUTTON_COUNT),
               .INITIAL_HALF_SPAN(INITIAL_HALF_SPAN)) u_front (
      .clock, .reset, .take, .levels(req_button_levels), .raw, .query(req_query_button),
      .btn(f_btn), .offset(f_off), .span(f_span));

   assign q_din = {f_btn, f_off[0], f_off[1], f_off[2], f_off[3],
                   f_span[0], f_span[1], f_span[2], f_span[3]};
   assign {b_btn, b_off[0], b_off[1], b_off[2], b_off[3],
           b_span[0], b_span[1], b_span[2], b_span[3]} = q_dout;

   gic_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(req_push), .din(q_din), .full(req_full),
      .pop(b_take), .dout(q_dout), .empty(q_empty));

   gic_back #(.ADC_BITS(ADC_BITS)) u_back (
      .clock, .reset, .in_valid(!q_empty), .in_take(b_take), .btn(b_btn),
      .offset(b_off), .span(b_span), .deadzone(dz_ff),
      .out_valid(o_valid), .out_take(rsp_pop), .out_btn(o_btn),
      .out_norm(o_norm), .out_active(rsp_stick1_active));

   assign rsp_empty          = !o_valid;
   assign rsp_held_mask      = o_btn.held;
   assign rsp_pressed_mask   = o_btn.pressed;
   assign rsp_released_mask  = o_btn.released;
   assign rsp_any_changed    = o_btn.changed;
   assign rsp_query_pressed  = o_btn.q_pressed;
   assign rsp_query_released = o_btn.q_released;
   assign rsp_query_held     = o_btn.q_held;
   assign rsp_stick1_x_norm  = o_norm[0];
   assign rsp_stick1_y_norm  = o_norm[1];
   assign rsp_stick2_x_norm  = o_norm[2];
   assign rsp_stick2_y_norm  = o_norm[3];
endmodule
